// ----- hdl/ulte_pkg.sv -----
// Package for the unsorted list table engine: sizes, field types, codes,
// the result bundle and the width conversion helpers. Depends on nothing.
package ulte_pkg;

  localparam int unsigned CAPACITY   = 128;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MPOS_W   = 7;
  localparam int unsigned FCNT_W   = 8;

  typedef logic [FUNC_W-1:0]     func_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [STATUS_W-1:0]   status_t;
  typedef logic [MPOS_W-1:0]     mpos_t;
  typedef logic [FCNT_W-1:0]     fcnt_t;
  typedef logic [DATA_WIDTH-1:0] value_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  localparam func_t OP_INSERT = 3'd0;
  localparam func_t OP_FIND   = 3'd1;
  localparam func_t OP_UPDATE = 3'd2;
  localparam func_t OP_ERASE  = 3'd3;
  localparam func_t OP_CLEAR  = 3'd4;
  localparam func_t OP_REWIND = 3'd5;
  localparam func_t OP_NEXT   = 3'd6;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_END       = 2'd3;

  typedef struct packed {
    func_t  func;
    value_t key;
    value_t repl;
  } req_t;

  typedef struct packed {
    status_t status;
    mpos_t   match_position;
    word_t   read_value;
    fcnt_t   entry_count;
    logic    is_empty;
    logic    is_full;
  } rsp_t;

  typedef struct packed {
    logic   we;
    addr_t  addr;
    value_t wdata;
  } ram_req_t;

  function automatic value_t word_to_value(word_t w);
    value_t v;
    v = '0;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      if (i < WORD_W) begin
        v[i] = w[i];
      end
    end
    return v;
  endfunction

  function automatic word_t value_to_word(value_t v);
    word_t w;
    w = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (i < DATA_WIDTH) begin
        w[i] = v[i];
      end
    end
    return w;
  endfunction

  function automatic mpos_t addr_to_mpos(addr_t a);
    mpos_t m;
    m = '0;
    for (int i = 0; i < MPOS_W; i++) begin
      if (i < ADDR_W) begin
        m[i] = a[i];
      end
    end
    return m;
  endfunction

  function automatic fcnt_t cnt_to_fcnt(cnt_t c);
    fcnt_t f;
    f = '0;
    for (int i = 0; i < FCNT_W; i++) begin
      if (i < CNT_W) begin
        f[i] = c[i];
      end
    end
    return f;
  endfunction

endpackage

// ----- hdl/ulte_if.sv -----
// Channel interfaces for the unsorted list table engine: request and response.
// Depends on ulte_pkg for the field types.
interface ulte_req_if import ulte_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  word_t key_value;
  word_t new_value;

  modport source (output valid, output func, output key_value, output new_value,
                  input ready);
  modport sink (input valid, input func, input key_value, input new_value,
                output ready);
endinterface

interface ulte_rsp_if import ulte_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  mpos_t   match_position;
  word_t   read_value;
  fcnt_t   entry_count;
  logic    is_empty;
  logic    is_full;

  modport source (output valid, output status, output match_position,
                  output read_value, output entry_count, output is_empty,
                  output is_full, input ready);
  modport sink (input valid, input status, input match_position,
                input read_value, input entry_count, input is_empty,
                input is_full, output ready);
endinterface

// ----- hdl/ulte_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module ulte_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ulte_ctrl.sv -----
// Sequencer of the unsorted list table engine: owns count and cursor, scans
// the entry RAM one slot a cycle and does the read-modify-write steps.
// Depends on ulte_pkg.
module ulte_ctrl import ulte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  req_t     req_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output rsp_t     res_o,
  output ram_req_t ram_o,
  input  value_t   ram_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_MOVE   = 5'b00100,
    S_RDWAIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  cnt_t    count_q, count_d;
  cnt_t    cursor_q, cursor_d;
  cnt_t    idx_q, idx_d;
  logic    pend_q, pend_d;
  addr_t   paddr_q, paddr_d;
  func_t   op_q, op_d;
  value_t  key_q, key_d;
  value_t  repl_q, repl_d;
  status_t status_q, status_d;
  addr_t   pos_q, pos_d;
  value_t  rd_q, rd_d;
  logic    hit;
  cnt_t    last;

  assign hit  = pend_q && (ram_rdata_i == key_q);
  assign last = count_q - cnt_t'(1);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    paddr_d  = paddr_q;
    op_d     = op_q;
    key_d    = key_q;
    repl_d   = repl_q;
    status_d = status_q;
    pos_d    = pos_q;
    rd_d     = rd_q;
    ram_o    = '{we: 1'b0, addr: '0, wdata: '0};
    req_ready_o = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d     = req_i.func;
          key_d    = req_i.key;
          repl_d   = req_i.repl;
          status_d = ST_OK;
          pos_d    = '0;
          rd_d     = '0;
          idx_d    = '0;
          pend_d   = 1'b0;
          state_d  = S_DONE;
          unique case (req_i.func)
            OP_INSERT: begin
              if (count_q >= CAP_CNT) begin
                status_d = ST_FULL;
              end else begin
                ram_o   = '{we: 1'b1, addr: count_q[ADDR_W-1:0], wdata: req_i.key};
                count_d = count_q + cnt_t'(1);
              end
            end
            OP_FIND, OP_UPDATE, OP_ERASE: begin
              state_d = S_SCAN;
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_REWIND: begin
              cursor_d = '0;
            end
            OP_NEXT: begin
              if (cursor_q >= count_q) begin
                status_d = ST_END;
              end else begin
                ram_o    = '{we: 1'b0, addr: cursor_q[ADDR_W-1:0], wdata: '0};
                cursor_d = cursor_q + cnt_t'(1);
                state_d  = S_RDWAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          pos_d   = paddr_q;
          pend_d  = 1'b0;
          state_d = S_DONE;
          if (op_q == OP_UPDATE) begin
            ram_o = '{we: 1'b1, addr: paddr_q, wdata: repl_q};
          end else if (op_q == OP_ERASE) begin
            if (cnt_t'(paddr_q) == last) begin
              count_d = last;
            end else begin
              ram_o   = '{we: 1'b0, addr: last[ADDR_W-1:0], wdata: '0};
              state_d = S_MOVE;
            end
          end
        end else if (idx_q < count_q) begin
          ram_o   = '{we: 1'b0, addr: idx_q[ADDR_W-1:0], wdata: '0};
          paddr_d = idx_q[ADDR_W-1:0];
          pend_d  = 1'b1;
          idx_d   = idx_q + cnt_t'(1);
        end else begin
          status_d = ST_NOT_FOUND;
          pend_d   = 1'b0;
          state_d  = S_DONE;
        end
      end
      S_MOVE: begin
        ram_o   = '{we: 1'b1, addr: pos_q, wdata: ram_rdata_i};
        count_d = last;
        state_d = S_DONE;
      end
      S_RDWAIT: begin
        rd_d    = ram_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    paddr_q  <= paddr_d;
    op_q     <= op_d;
    key_q    <= key_d;
    repl_q   <= repl_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    rd_q     <= rd_d;
  end

  assign res_o = '{
    status:         status_q,
    match_position: addr_to_mpos(pos_q),
    read_value:     value_to_word(rd_q),
    entry_count:    cnt_to_fcnt(count_q),
    is_empty:       (count_q == '0),
    is_full:        (count_q == CAP_CNT)
  };

endmodule

// ----- hdl/unsorted_list_table_engine.sv -----
// Channel    | Dir | Beat contents
// req_i      | in  | func, key_value, new_value
// rsp_o      | out | status, match_position, read_value, entry_count, is_empty, is_full
//
// One request is in work at a time. Find, update and erase scan the entries;
// the scan reads one slot per cycle through the single RAM port.
// Reset clears count, cursor and the response valid flag; entry contents stay
// undefined until written. A stalled response is held in the output register
// while the next request is accepted and worked on.
//
// Top level of the unsorted list table engine: sequencer, entry RAM and the
// response register. Depends on ulte_pkg, ulte_if, ulte_ram and ulte_ctrl.
module unsorted_list_table_engine import ulte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ulte_req_if.sink          req_i,
  ulte_rsp_if.source        rsp_o
);

  req_t     req;
  rsp_t     res;
  logic     res_valid;
  logic     res_ready;
  ram_req_t ram_req;
  value_t   ram_rdata;
  logic     out_valid_q;
  rsp_t     out_q;

  assign req = '{
    func: req_i.func,
    key:  word_to_value(req_i.key_value),
    repl: word_to_value(req_i.new_value)
  };

  ulte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  ulte_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.match_position = out_q.match_position;
  assign rsp_o.read_value     = out_q.read_value;
  assign rsp_o.entry_count    = out_q.entry_count;
  assign rsp_o.is_empty       = out_q.is_empty;
  assign rsp_o.is_full        = out_q.is_full;

endmodule

// ----- hdl/ulte_chk.sv -----
// Port-level checker for the unsorted list table engine and its bind.
// Depends on ulte_pkg and the top level's ports.
module ulte_chk import ulte_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input status_t status,
  input mpos_t   match_position,
  input word_t   read_value,
  input fcnt_t   entry_count,
  input logic    is_empty,
  input logic    is_full
);

  localparam fcnt_t CAP_F = cnt_to_fcnt(CAP_CNT);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(match_position) && $stable(read_value) && $stable(entry_count))
    else $error("Response beat changed while stalled.");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (is_empty == (entry_count == '0)) &&
      (is_full == (entry_count == CAP_F)))
    else $error("Empty or full flag disagrees with the entry count.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (status != ST_OK) |-> (match_position == '0) && (read_value == '0))
    else $error("Failed operation returned a nonzero position or value.");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (status == ST_FULL) |-> is_full)
    else $error("Table full reported while the table is not full.");

endmodule

bind unsorted_list_table_engine ulte_chk u_ulte_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid      (rsp_o.valid),
  .rsp_ready      (rsp_o.ready),
  .status         (rsp_o.status),
  .match_position (rsp_o.match_position),
  .read_value     (rsp_o.read_value),
  .entry_count    (rsp_o.entry_count),
  .is_empty       (rsp_o.is_empty),
  .is_full        (rsp_o.is_full)
);
